// ===== design/audio_level_meter_core_assert.svh =====
// Assertion macros shared by the level meter RTL.
`ifndef AUDIO_LEVEL_METER_CORE_ASSERT_SVH
`define AUDIO_LEVEL_METER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ALM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/alm_pkg.sv =====
// Shared constants, types and helpers of the audio level meter.
package alm_pkg;

	localparam int CHANNELS = 2;
	localparam int SAMPLE_W = 24;
	localparam int SUM_W = 62;
	localparam int COUNT_W = 16;
	localparam int ITER_W = 6;
	localparam int DIV_STEPS = SUM_W;
	localparam int SQRT_STEPS = SUM_W / 2;

	localparam logic [15:0] DECAY_RESET = 16'd62259;
	localparam logic [15:0] WINDOW_RESET = 16'd2048;
	localparam logic STEREO_RESET = 1'b1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [SAMPLE_W-1:0] LEVEL_MAX = 24'd8388608;

	// Configuration register indexes.
	localparam logic [1:0] REG_DECAY = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_STEREO = 2'd2;

	// Per-step commands from the sequencer to every lane.
	typedef struct packed {
		logic clear;
		logic load;
		logic mul;
		logic acc;
		logic peak;
		logic rms_start;
	} lane_ctl_t;

	// Magnitude of a two's complement sample; the most negative maps to 2^23.
	function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] r;
		r = s[SAMPLE_W-1] ? (~s + 24'd1) : s;
		return r;
	endfunction

endpackage

// ===== design/alm_lane.sv =====
// One metering lane: peak tracking, square sum, divider and square root.
module alm_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            active,
	input  alm_pkg::lane_ctl_t              ctl,
	input  logic [alm_pkg::SAMPLE_W-1:0]    sample,
	input  logic [15:0]                     decay,
	input  logic [alm_pkg::COUNT_W-1:0]     count,
	output logic [alm_pkg::SAMPLE_W-1:0]    held_peak,
	output logic [alm_pkg::SAMPLE_W-1:0]    rms_level,
	output logic                            busy,
	output logic                            done
);

	logic [alm_pkg::SAMPLE_W-1:0] mag_q;
	logic [2*alm_pkg::SAMPLE_W-1:0] sq_s1;
	logic [alm_pkg::SAMPLE_W-1:0] held_q, block_q, rms_q;
	logic [alm_pkg::SUM_W-1:0] sum_q;
	logic [alm_pkg::SUM_W:0] sum_next;
	logic [alm_pkg::SAMPLE_W+15:0] decay_prod;

	logic busy_q, sqrt_phase_q, done_q;
	logic [alm_pkg::ITER_W-1:0] iter_q;
	logic [alm_pkg::SUM_W-1:0] work_q;
	logic [alm_pkg::COUNT_W-1:0] den_q, rem_q;
	logic [alm_pkg::COUNT_W:0] div_trial;
	logic [alm_pkg::SQRT_STEPS+1:0] srem_q, sq_trial, sq_test;
	logic [alm_pkg::SQRT_STEPS-1:0] root_q;
	logic [alm_pkg::SQRT_STEPS-1:0] root_next;

	assign sum_next = {1'b0, sum_q} + {{(alm_pkg::SUM_W+1-2*alm_pkg::SAMPLE_W){1'b0}}, sq_s1};
	assign decay_prod = held_q * decay;
	assign div_trial = {rem_q, work_q[alm_pkg::SUM_W-1]};
	assign sq_trial = {srem_q[alm_pkg::SQRT_STEPS-1:0], work_q[alm_pkg::SUM_W-1 -: 2]};
	assign sq_test = {root_q, 2'b01};
	assign root_next = {root_q[alm_pkg::SQRT_STEPS-2:0], (sq_trial >= sq_test)};

	// Accumulation and peak hold, stepped by the sequencer, and the saturated RMS result of the root unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			block_q <= '0;
			sum_q <= '0;
			rms_q <= '0;
		end else begin
			if (ctl.clear) begin
				held_q <= '0;
				block_q <= '0;
				sum_q <= '0;
				rms_q <= '0;
			end
			if (active && ctl.acc) begin
				if (mag_q > block_q) begin
					block_q <= mag_q;
				end
				sum_q <= sum_next[alm_pkg::SUM_W] ? alm_pkg::SUM_MAX
					: sum_next[alm_pkg::SUM_W-1:0];
			end
			if (active && ctl.peak) begin
				held_q <= (block_q > held_q) ? block_q : decay_prod[alm_pkg::SAMPLE_W+15:16];
				block_q <= '0;
			end
			if (busy_q && sqrt_phase_q && iter_q == alm_pkg::ITER_W'(alm_pkg::SQRT_STEPS - 1)) begin
				rms_q <= ({1'b0, root_next} > {8'd0, alm_pkg::LEVEL_MAX}) ? alm_pkg::LEVEL_MAX
					: root_next[alm_pkg::SAMPLE_W-1:0];
				sum_q <= '0;
			end
		end
	end

	// Magnitude and square, one register stage each.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_q <= alm_pkg::magnitude(sample);
		end
		if (ctl.mul) begin
			sq_s1 <= mag_q * mag_q;
		end
	end

	// Restoring divide of the sum by the count, then digit-by-digit square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sqrt_phase_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (active && ctl.rms_start) begin
				busy_q <= 1'b1;
				sqrt_phase_q <= 1'b0;
				iter_q <= '0;
			end else if (busy_q) begin
				if (!sqrt_phase_q) begin
					if (iter_q == alm_pkg::ITER_W'(alm_pkg::DIV_STEPS - 1)) begin
						sqrt_phase_q <= 1'b1;
						iter_q <= '0;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end else if (iter_q == alm_pkg::ITER_W'(alm_pkg::SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + 1'b1;
				end
			end
		end
	end

	// Datapath of the divider and root unit.
	always_ff @(posedge clk) begin
		if (active && ctl.rms_start) begin
			work_q <= sum_q;
			den_q <= count;
			rem_q <= '0;
			srem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (!sqrt_phase_q) begin
				if (div_trial >= {1'b0, den_q}) begin
					rem_q <= alm_pkg::COUNT_W'(div_trial - {1'b0, den_q});
					work_q <= {work_q[alm_pkg::SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= div_trial[alm_pkg::COUNT_W-1:0];
					work_q <= {work_q[alm_pkg::SUM_W-2:0], 1'b0};
				end
			end else begin
				srem_q <= (sq_trial >= sq_test) ? (sq_trial - sq_test) : sq_trial;
				root_q <= root_next;
				work_q <= {work_q[alm_pkg::SUM_W-3:0], 2'b00};
			end
		end
	end

	assign held_peak = held_q;
	assign rms_level = rms_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== design/audio_level_meter_core.sv =====
// Top level of the stereo peak-hold and RMS level meter.
// Usage: one input beat carries a stereo frame (sample_left, sample_right,
// block_end, restart) on in_valid/in_ready; one output beat per frame carries
// the held peaks, the latest RMS levels and rms_updated on out_valid/out_ready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// A frame passes the states MUL, ACC and OUT before its output beat is
// registered; a block end adds PEAK and, once the frame count has reached
// the window, WAIT, in which each active lane runs a one-bit-per-cycle restoring
// divider over the 62-bit sum, then a square root that yields one bit a cycle.
// The next frame is taken once the previous one has finished its work.
// Each channel has its own lane; the sequencer steps both lanes together and
// merges their levels into the output register.
// Reset clears all levels, sums and the frame count, and loads the register
// defaults. A stalled receiver leaves the result in the output register; a
// new frame is still taken and worked on, and waits to be shown until the
// pending beat is taken.
module audio_level_meter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] sample_left,
	input  logic [23:0] sample_right,
	input  logic        block_end,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] peak_left,
	output logic [23:0] peak_right,
	output logic [23:0] rms_left,
	output logic [23:0] rms_right,
	output logic        rms_updated
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_PEAK = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [15:0] decay_q, window_q;
	logic stereo_q, last_q, updated_q;
	logic [alm_pkg::COUNT_W-1:0] count_q;
	alm_pkg::lane_ctl_t ctl;
	logic accept, out_free, lanes_done;
	logic [alm_pkg::CHANNELS-1:0] lane_active, lane_busy, lane_done;
	logic [alm_pkg::SAMPLE_W-1:0] lane_sample [alm_pkg::CHANNELS];
	logic [alm_pkg::SAMPLE_W-1:0] lane_peak [alm_pkg::CHANNELS];
	logic [alm_pkg::SAMPLE_W-1:0] lane_rms [alm_pkg::CHANNELS];
	logic out_valid_q, upd_q;
	logic [23:0] peak_l_q, peak_r_q, rms_l_q, rms_r_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign lanes_done = lane_done[0] && (lane_done[1] || !stereo_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= alm_pkg::DECAY_RESET;
			window_q <= alm_pkg::WINDOW_RESET;
			stereo_q <= alm_pkg::STEREO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				alm_pkg::REG_DECAY:  decay_q <= cfg_data;
				alm_pkg::REG_WINDOW: window_q <= cfg_data;
				alm_pkg::REG_STEREO: stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Lane commands decoded from the sequencer state.
	always_comb begin
		ctl = '0;
		ctl.clear = accept && restart;
		ctl.load = accept;
		ctl.mul = (state_q == ST_MUL);
		ctl.acc = (state_q == ST_ACC);
		ctl.peak = (state_q == ST_PEAK);
		ctl.rms_start = (state_q == ST_PEAK) && (count_q >= window_q);
	end

	// Sequencer and shared frame counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			last_q <= 1'b0;
			updated_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= block_end;
						updated_q <= 1'b0;
						if (restart) begin
							count_q <= '0;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (count_q != alm_pkg::COUNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= last_q ? ST_PEAK : ST_OUT;
				end
				ST_PEAK: state_q <= ctl.rms_start ? ST_WAIT : ST_OUT;
				ST_WAIT: begin
					if (lanes_done) begin
						count_q <= '0;
						updated_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// One lane per channel; the right lane holds still in mono, but a restart still clears it.
	assign lane_sample[0] = sample_left;
	assign lane_sample[1] = sample_right;
	assign lane_active[0] = 1'b1;
	assign lane_active[1] = stereo_q;

	for (genvar g = 0; g < alm_pkg::CHANNELS; g++) begin : g_lane
		alm_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.active    (lane_active[g]),
			.ctl       (ctl),
			.sample    (lane_sample[g]),
			.decay     (decay_q),
			.count     (count_q),
			.held_peak (lane_peak[g]),
			.rms_level (lane_rms[g]),
			.busy      (lane_busy[g]),
			.done      (lane_done[g])
		);
	end

	// Output register merging the lane levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			peak_l_q <= lane_peak[0];
			peak_r_q <= lane_peak[1];
			rms_l_q <= lane_rms[0];
			rms_r_q <= lane_rms[1];
			upd_q <= updated_q;
		end
	end

	assign out_valid = out_valid_q;
	assign peak_left = peak_l_q;
	assign peak_right = peak_r_q;
	assign rms_left = rms_l_q;
	assign rms_right = rms_r_q;
	assign rms_updated = upd_q;

	`include "audio_level_meter_core_assert.svh"

	`ALM_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_MUL, "accepted beat did not start work")
	`ALM_ASSERT_NOW(a_wait_busy, state_q == ST_WAIT && !lanes_done, lane_busy[0], "waiting with idle lane")
	`ALM_ASSERT_NOW(a_rms_range, out_valid_q, rms_l_q <= alm_pkg::LEVEL_MAX && rms_r_q <= alm_pkg::LEVEL_MAX, "rms out of range")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the stereo peak-hold and RMS level meter.
`timescale 1ns / 1ps

module tb;

	// One frame as driven on the input channel.
	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
		logic        last;
		logic        rst;
		logic        has_peak;
		logic [23:0] peak_l;
	} frame_t;

	// One expected output beat.
	typedef struct {
		logic [23:0] peak_l;
		logic [23:0] peak_r;
		logic [23:0] rms_l;
		logic [23:0] rms_r;
		logic        upd;
	} level_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = alm_pkg::REG_DECAY;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [23:0] sample_left = '0;
	logic [23:0] sample_right = '0;
	logic        block_end = 1'b0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] peak_left;
	logic [23:0] peak_right;
	logic [23:0] rms_left;
	logic [23:0] rms_right;
	logic        rms_updated;

	audio_level_meter_core uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the meter state and registers.
	logic [15:0] m_decay;
	logic [15:0] m_window;
	logic        m_stereo;
	logic [23:0] m_held [2];
	logic [23:0] m_blk [2];
	logic [61:0] m_sum [2];
	logic [15:0] m_count;
	logic [23:0] m_rms [2];

	level_t levels_due [$];
	int     errors = 0;

	function automatic logic [23:0] abs24(logic [23:0] s);
		logic [24:0] w;
		w = s[23] ? (25'h1000000 - {1'b0, s}) : {1'b0, s};
		return w[23:0];
	endfunction

	// Floor square root, one result bit at a time from the top.
	function automatic logic [31:0] root_floor(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r[31:0];
	endfunction

	function automatic void clear_levels();
		for (int c = 0; c < 2; c++) begin
			m_held[c] = '0;
			m_blk[c] = '0;
			m_sum[c] = '0;
			m_rms[c] = '0;
		end
		m_count = '0;
	endfunction

	// Advance the shadow state by one frame and return the levels it shows.
	function automatic level_t meter_frame(frame_t f);
		level_t      o;
		logic [23:0] mag [2];
		logic [63:0] acc;
		logic [63:0] q;
		logic [31:0] r;
		logic [39:0] prod;
		int          nch;
		nch = m_stereo ? 2 : 1;
		o.upd = 1'b0;
		if (f.rst)
			clear_levels();
		mag[0] = abs24(f.left);
		mag[1] = abs24(f.right);
		for (int c = 0; c < nch; c++) begin
			if (mag[c] > m_blk[c])
				m_blk[c] = mag[c];
			acc = {2'b0, m_sum[c]} + 64'(mag[c]) * 64'(mag[c]);
			m_sum[c] = (acc > 64'(alm_pkg::SUM_MAX)) ? alm_pkg::SUM_MAX : acc[61:0];
		end
		if (m_count != alm_pkg::COUNT_MAX)
			m_count++;
		if (f.last) begin
			for (int c = 0; c < nch; c++) begin
				if (m_blk[c] > m_held[c]) begin
					m_held[c] = m_blk[c];
				end else begin
					prod = 40'(m_held[c]) * 40'(m_decay);
					m_held[c] = prod[39:16];
				end
				m_blk[c] = '0;
			end
			if (m_count >= m_window && m_count != 0) begin
				for (int c = 0; c < nch; c++) begin
					q = 64'(m_sum[c]) / 64'(m_count);
					r = root_floor(q);
					m_rms[c] = (r > 32'(alm_pkg::LEVEL_MAX)) ? alm_pkg::LEVEL_MAX : r[23:0];
					m_sum[c] = '0;
				end
				m_count = '0;
				o.upd = 1'b1;
			end
		end
		o.peak_l = m_held[0];
		o.peak_r = m_held[1];
		o.rms_l = m_rms[0];
		o.rms_r = m_rms[1];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Receiver: compare each output beat, stall on a pattern that changes mode.
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		level_t e;
		if (out_valid && out_ready) begin
			if (levels_due.size() == 0) begin
				$display("unexpected output beat at %0t", $realtime);
				errors++;
			end else begin
				e = levels_due.pop_front();
				if (peak_left !== e.peak_l)
					report_mismatch("peak_left", peak_left, e.peak_l);
				if (peak_right !== e.peak_r)
					report_mismatch("peak_right", peak_right, e.peak_r);
				if (rms_left !== e.rms_l)
					report_mismatch("rms_left", rms_left, e.rms_l);
				if (rms_right !== e.rms_r)
					report_mismatch("rms_right", rms_right, e.rms_r);
				if (rms_updated !== e.upd)
					report_mismatch("rms_updated", rms_updated, e.upd);
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(50, 400);
		end
		stall_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Drives one register write; the caller drops the enable.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			alm_pkg::REG_DECAY: m_decay = val;
			alm_pkg::REG_WINDOW: m_window = val;
			default: m_stereo = val[0];
		endcase
	endtask

	// Waits for the block to drain, then loads all three registers.
	task automatic setup_meter(logic [15:0] decay, logic [15:0] window, logic stereo);
		in_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
		write_reg(alm_pkg::REG_DECAY, decay);
		write_reg(alm_pkg::REG_WINDOW, window);
		write_reg(alm_pkg::REG_STEREO, stereo);
		cfg_we <= 1'b0;
	endtask

	// Sender: present one beat and hold it until accepted.
	int burst_left = 0;
	task automatic send_frame(frame_t f);
		level_t e;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_left <= f.left;
		sample_right <= f.right;
		block_end <= f.last;
		restart <= f.rst;
		do
			@(posedge clk);
		while (!in_ready);
		e = meter_frame(f);
		if (f.has_peak)
			e.peak_l = f.peak_l;
		levels_due.push_back(e);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'(signed'($urandom_range(0, 512)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic frame_t mk(logic [23:0] l, logic [23:0] r, logic last, logic rst,
			logic hp = 1'b0, logic [23:0] pk = '0);
		frame_t f;
		f.left = l;
		f.right = r;
		f.last = last;
		f.rst = rst;
		f.has_peak = hp;
		f.peak_l = pk;
		return f;
	endfunction

	task automatic random_frames(int n);
		frame_t f;
		for (int i = 0; i < n; i++) begin
			f = mk(rand_sample(), rand_sample(), $urandom_range(0, 3) == 0,
				$urandom_range(0, 40) == 0);
			send_frame(f);
		end
	endtask

	frame_t directed [$];

	initial begin
		m_decay = alm_pkg::DECAY_RESET;
		m_window = alm_pkg::WINDOW_RESET;
		m_stereo = alm_pkg::STEREO_RESET;
		clear_levels();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under small windows: extremes, restart, decay, mono.
		directed = '{
			mk(24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 1'b1, 24'd8388608),
			mk(24'h000000, 24'h000000, 1'b1, 1'b0),
			mk(24'h7FFFFF, 24'h800000, 1'b0, 1'b0),
			mk(24'h000001, 24'hFFFFFF, 1'b1, 1'b0),
			mk(24'h000010, 24'h000020, 1'b1, 1'b1, 1'b1, 24'd16),
			mk(24'hFFFFF0, 24'h000000, 1'b0, 1'b0),
			mk(24'h000000, 24'h000000, 1'b1, 1'b0),
			mk(24'h000000, 24'h000000, 1'b1, 1'b1, 1'b1, 24'd0),
			mk(24'h123456, 24'hABCDEF, 1'b1, 1'b0)
		};
		setup_meter(16'd65535, 16'd1, 1'b1);
		foreach (directed[i])
			send_frame(directed[i]);
		setup_meter(16'd0, 16'd0, 1'b0);
		foreach (directed[i])
			send_frame(directed[i]);

		// Random phases sweeping decay, window and channel mode.
		setup_meter(16'd62259, 16'd3, 1'b1);
		random_frames(200);
		setup_meter(16'd0, 16'd0, 1'b0);
		random_frames(150);
		setup_meter(16'd65535, 16'd1, 1'b1);
		random_frames(150);
		setup_meter(16'($urandom), 16'd8, 1'b1);
		random_frames(150);
		setup_meter(16'd32768, 16'd65535, 1'b0);
		random_frames(30);

		in_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

endmodule
